### rtl/core/bkp_pkg.sv
// ----------------------------------------------------------------------------
// bkp_pkg
// Shared types and constants for the depth pixel back-projection block.
// ----------------------------------------------------------------------------
package bkp_pkg;

  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned StepWidth   = 4;
  localparam int unsigned ColorWidth  = 8;
  localparam int unsigned OutWidth    = 32;
  localparam int unsigned ZWidth      = 16;
  localparam int unsigned SubpixBits  = 4;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [OutWidth-1:0] SatMax = 32'h7fff_ffff;
  localparam logic [OutWidth-1:0] SatMin = 32'h8000_0000;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_FOCAL_X   = 3'd0,
    CFG_FOCAL_Y   = 3'd1,
    CFG_CENTER_X  = 3'd2,
    CFG_CENTER_Y  = 3'd3,
    CFG_MIN_DEPTH = 3'd4,
    CFG_MAX_DEPTH = 3'd5,
    CFG_STEP      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgWidth-1:0]  focal_x;
    logic [CfgWidth-1:0]  focal_y;
    logic [CfgWidth-1:0]  center_x;
    logic [CfgWidth-1:0]  center_y;
    logic [CfgWidth-1:0]  min_depth;
    logic [CfgWidth-1:0]  max_depth;
    logic [StepWidth-1:0] step;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    focal_x:   16'd8400,
    focal_y:   16'd8400,
    center_x:  16'd5112,
    center_y:  16'd3832,
    min_depth: 16'd10,
    max_depth: 16'd8000,
    step:      4'd2
  };

  typedef struct packed {
    logic [ColorWidth-1:0] red;
    logic [ColorWidth-1:0] green;
    logic [ColorWidth-1:0] blue;
  } color_t;

  // Per-transaction control that travels down the pipeline.
  typedef struct packed {
    logic valid;
    logic depth_ok;
    logic grid_ok;
    logic neg_x;
    logic neg_y;
    logic nz_x;
    logic nz_y;
  } ctrl_t;

endpackage

### rtl/core/bkp_if.sv
// ----------------------------------------------------------------------------
// bkp_if
// Valid/ready channel interfaces for depth pixels and projected points.
// ----------------------------------------------------------------------------
interface bkp_pixel_if #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DEPTH_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_row;
  logic [COORD_BITS-1:0] pixel_col;
  logic [DEPTH_BITS-1:0] depth_mm;
  logic [7:0]            color_byte_zero;
  logic [7:0]            color_byte_one;
  logic [7:0]            color_byte_two;

  modport source (
    output valid, pixel_row, pixel_col, depth_mm,
    output color_byte_zero, color_byte_one, color_byte_two,
    input  ready
  );
  modport sink (
    input  valid, pixel_row, pixel_col, depth_mm,
    input  color_byte_zero, color_byte_one, color_byte_two,
    output ready
  );
endinterface

interface bkp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x_mm;
  logic signed [31:0] point_y_mm;
  logic [15:0]        point_z_mm;
  logic [7:0]         point_red;
  logic [7:0]         point_green;
  logic [7:0]         point_blue;

  modport source (
    output valid, point_x_mm, point_y_mm, point_z_mm,
    output point_red, point_green, point_blue,
    input  ready
  );
  modport sink (
    input  valid, point_x_mm, point_y_mm, point_z_mm,
    input  point_red, point_green, point_blue,
    output ready
  );
endinterface

### rtl/core/bkp_front.sv
// ----------------------------------------------------------------------------
// bkp_front
// Input stage and multiplier stage: offsets from the principal point, depth
// window test, and the magnitude of offset times depth for both axes.
// ----------------------------------------------------------------------------
module bkp_front import bkp_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DEPTH_BITS = 16,
  localparam int unsigned DiffBits =
    (COORD_BITS + SubpixBits > CfgWidth) ? COORD_BITS + SubpixBits : CfgWidth,
  localparam int unsigned ProdBits = DiffBits + DEPTH_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [COORD_BITS-1:0] row_i,
  input  logic [COORD_BITS-1:0] col_i,
  input  logic [DEPTH_BITS-1:0] depth_i,
  input  color_t                color_i,
  input  cfg_t                  cfg_i,
  output ctrl_t                 ctrl_o,
  output logic [ProdBits-1:0]   prod_x_o,
  output logic [ProdBits-1:0]   prod_y_o,
  output logic [COORD_BITS-1:0] row_o,
  output logic [COORD_BITS-1:0] col_o,
  output logic [DEPTH_BITS-1:0] depth_o,
  output color_t                color_o
);

  localparam int unsigned ZW = (DEPTH_BITS > CfgWidth) ? DEPTH_BITS : CfgWidth;

  logic [DiffBits:0]   dx, dy, ndx, ndy;
  logic [DiffBits-1:0] ax, ay;
  ctrl_t               ctrl_a_d, ctrl_a_q, ctrl_b_q;
  logic [DiffBits-1:0] ax_a_q, ay_a_q;
  logic [DEPTH_BITS-1:0] depth_a_q, depth_b_q;
  color_t              color_a_q, color_b_q;
  logic [COORD_BITS-1:0] row_a_q, col_a_q, row_b_q, col_b_q;
  logic [ProdBits-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;

  // Positions are in whole pixels; scale to 1/16 pixel before the offset.
  assign dx  = (DiffBits+1)'({col_i, {SubpixBits{1'b0}}}) - (DiffBits+1)'(cfg_i.center_x);
  assign dy  = (DiffBits+1)'({row_i, {SubpixBits{1'b0}}}) - (DiffBits+1)'(cfg_i.center_y);
  assign ndx = -dx;
  assign ndy = -dy;
  assign ax  = dx[DiffBits] ? ndx[DiffBits-1:0] : dx[DiffBits-1:0];
  assign ay  = dy[DiffBits] ? ndy[DiffBits-1:0] : dy[DiffBits-1:0];

  always_comb begin
    ctrl_a_d.valid    = valid_i;
    ctrl_a_d.depth_ok = (ZW'(depth_i) >= ZW'(cfg_i.min_depth)) &&
                        (ZW'(depth_i) <= ZW'(cfg_i.max_depth));
    ctrl_a_d.grid_ok  = 1'b0;
    ctrl_a_d.neg_x    = dx[DiffBits];
    ctrl_a_d.neg_y    = dy[DiffBits];
    ctrl_a_d.nz_x     = (ax != '0) && (depth_i != '0);
    ctrl_a_d.nz_y     = (ay != '0) && (depth_i != '0);
  end

  assign prod_x_d = ProdBits'(ax_a_q) * ProdBits'(depth_a_q);
  assign prod_y_d = ProdBits'(ay_a_q) * ProdBits'(depth_a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
      ctrl_b_q <= '0;
    end else if (en_i) begin
      ctrl_a_q <= ctrl_a_d;
      ctrl_b_q <= ctrl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_a_q    <= ax;
      ay_a_q    <= ay;
      depth_a_q <= depth_i;
      color_a_q <= color_i;
      row_a_q   <= row_i;
      col_a_q   <= col_i;
      prod_x_q  <= prod_x_d;
      prod_y_q  <= prod_y_d;
      depth_b_q <= depth_a_q;
      color_b_q <= color_a_q;
      row_b_q   <= row_a_q;
      col_b_q   <= col_a_q;
    end
  end

  assign ctrl_o   = ctrl_b_q;
  assign prod_x_o = prod_x_q;
  assign prod_y_o = prod_y_q;
  assign row_o    = row_b_q;
  assign col_o    = col_b_q;
  assign depth_o  = depth_b_q;
  assign color_o  = color_b_q;

endmodule

### rtl/core/bkp_lane.sv
// ----------------------------------------------------------------------------
// bkp_lane
// One registered restoring division step: brings down the next dividend bit,
// subtracts the divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module bkp_lane #(
  parameter int unsigned WW = 32,
  parameter int unsigned RW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] div_i,
  input  logic [RW-1:0] rem_i,
  input  logic [WW-1:0] work_i,
  output logic [RW-1:0] rem_o,
  output logic [WW-1:0] work_o
);

  logic [RW:0]   trial, diff;
  logic          ge;
  logic [RW-1:0] rem_q;
  logic [WW-1:0] work_q;

  // The work word holds the remaining dividend bits on top and the quotient
  // bits collected so far at the bottom.
  assign trial = {rem_i, work_i[WW-1]};
  assign diff  = trial - {1'b0, div_i};
  assign ge    = trial >= {1'b0, div_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= ge ? diff[RW-1:0] : trial[RW-1:0];
      work_q <= {work_i[WW-2:0], ge};
    end
  end

  assign rem_o  = rem_q;
  assign work_o = work_q;

endmodule

### rtl/core/bkp_cell.sv
// ----------------------------------------------------------------------------
// bkp_cell
// One cell of the projection chain: a quotient bit for each axis, a bit of
// the subsampling remainder for row and column in the early cells, and the
// transaction's side data.
// ----------------------------------------------------------------------------
module bkp_cell import bkp_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned IDX        = 0,
  localparam int unsigned DiffBits =
    (COORD_BITS + SubpixBits > CfgWidth) ? COORD_BITS + SubpixBits : CfgWidth,
  localparam int unsigned ProdBits = DiffBits + DEPTH_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [CfgWidth-1:0]   focal_x_i,
  input  logic [CfgWidth-1:0]   focal_y_i,
  input  logic [StepWidth-1:0]  step_i,
  input  ctrl_t                 ctrl_i,
  input  logic [CfgWidth-1:0]   rem_x_i,
  input  logic [ProdBits-1:0]   work_x_i,
  input  logic [CfgWidth-1:0]   rem_y_i,
  input  logic [ProdBits-1:0]   work_y_i,
  input  logic [StepWidth-1:0]  row_rem_i,
  input  logic [COORD_BITS-1:0] row_work_i,
  input  logic [StepWidth-1:0]  col_rem_i,
  input  logic [COORD_BITS-1:0] col_work_i,
  input  logic [DEPTH_BITS-1:0] depth_i,
  input  color_t                color_i,
  output ctrl_t                 ctrl_o,
  output logic [CfgWidth-1:0]   rem_x_o,
  output logic [ProdBits-1:0]   work_x_o,
  output logic [CfgWidth-1:0]   rem_y_o,
  output logic [ProdBits-1:0]   work_y_o,
  output logic [StepWidth-1:0]  row_rem_o,
  output logic [COORD_BITS-1:0] row_work_o,
  output logic [StepWidth-1:0]  col_rem_o,
  output logic [COORD_BITS-1:0] col_work_o,
  output logic [DEPTH_BITS-1:0] depth_o,
  output color_t                color_o
);

  ctrl_t                 ctrl_d, ctrl_q;
  logic [DEPTH_BITS-1:0] depth_q;
  color_t                color_q;

  bkp_lane #(.WW(ProdBits), .RW(CfgWidth)) u_lane_x (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .div_i  (focal_x_i),
    .rem_i  (rem_x_i),
    .work_i (work_x_i),
    .rem_o  (rem_x_o),
    .work_o (work_x_o)
  );

  bkp_lane #(.WW(ProdBits), .RW(CfgWidth)) u_lane_y (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .div_i  (focal_y_i),
    .rem_i  (rem_y_i),
    .work_i (work_y_i),
    .rem_o  (rem_y_o),
    .work_o (work_y_o)
  );

  if (IDX < COORD_BITS) begin : g_grid
    bkp_lane #(.WW(COORD_BITS), .RW(StepWidth)) u_lane_row (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .div_i  (step_i),
      .rem_i  (row_rem_i),
      .work_i (row_work_i),
      .rem_o  (row_rem_o),
      .work_o (row_work_o)
    );
    bkp_lane #(.WW(COORD_BITS), .RW(StepWidth)) u_lane_col (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .div_i  (step_i),
      .rem_i  (col_rem_i),
      .work_i (col_work_i),
      .rem_o  (col_rem_o),
      .work_o (col_work_o)
    );
  end else begin : g_no_grid
    assign row_rem_o  = '0;
    assign row_work_o = '0;
    assign col_rem_o  = '0;
    assign col_work_o = '0;
  end

  // The cell right after the last remainder step turns both remainders into
  // the subsampling verdict.
  always_comb begin
    ctrl_d = ctrl_i;
    if (IDX == COORD_BITS) begin
      ctrl_d.grid_ok = (row_rem_i == '0) && (col_rem_i == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      depth_q <= depth_i;
      color_q <= color_i;
    end
  end

  assign ctrl_o  = ctrl_q;
  assign depth_o = depth_q;
  assign color_o = color_q;

endmodule

### rtl/core/bkp_back.sv
// ----------------------------------------------------------------------------
// bkp_back
// Sign and saturation of the quotients, output register and the pipeline
// advance control.
// ----------------------------------------------------------------------------
module bkp_back import bkp_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DEPTH_BITS = 16,
  localparam int unsigned DiffBits =
    (COORD_BITS + SubpixBits > CfgWidth) ? COORD_BITS + SubpixBits : CfgWidth,
  localparam int unsigned ProdBits = DiffBits + DEPTH_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  input  logic [ProdBits-1:0]   mag_x_i,
  input  logic [ProdBits-1:0]   mag_y_i,
  input  logic [DEPTH_BITS-1:0] depth_i,
  input  color_t                color_i,
  input  logic [CfgWidth-1:0]   focal_x_i,
  input  logic [CfgWidth-1:0]   focal_y_i,
  input  logic                  out_ready_i,
  output logic                  adv_o,
  output logic                  out_valid_o,
  output logic [OutWidth-1:0]   x_o,
  output logic [OutWidth-1:0]   y_o,
  output logic [ZWidth-1:0]     z_o,
  output color_t                color_o
);

  localparam int unsigned EW = (ProdBits > OutWidth + 1) ? ProdBits : OutWidth + 1;

  function automatic logic [OutWidth-1:0] sat_coord(
    input logic [ProdBits-1:0] mag,
    input logic                neg,
    input logic                nz,
    input logic                zero_focal
  );
    logic [EW-1:0]       m;
    logic [EW-1:0]       nm;
    logic                big;
    logic [OutWidth-1:0] res;
    m   = EW'(mag);
    nm  = -m;
    big = |m[EW-1:OutWidth-1];
    if (zero_focal) begin
      res = nz ? (neg ? SatMin : SatMax) : '0;
    end else if (neg) begin
      res = big ? SatMin : nm[OutWidth-1:0];
    end else begin
      res = big ? SatMax : m[OutWidth-1:0];
    end
    return res;
  endfunction

  logic                live;
  logic                out_valid_q;
  logic [OutWidth-1:0] x_q, y_q;
  logic [ZWidth-1:0]   z_q;
  color_t              color_q;

  assign live  = ctrl_i.valid && ctrl_i.depth_ok && ctrl_i.grid_ok;
  // A dropped or empty slot at the end never holds the chain back.
  assign adv_o = !out_valid_q || out_ready_i || !live;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (live && adv_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (live && adv_o) begin
      x_q     <= sat_coord(mag_x_i, ctrl_i.neg_x, ctrl_i.nz_x, focal_x_i == '0);
      y_q     <= sat_coord(mag_y_i, ctrl_i.neg_y, ctrl_i.nz_y, focal_y_i == '0);
      z_q     <= ZWidth'(depth_i);
      color_q <= color_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign z_o         = z_q;
  assign color_o     = color_q;

endmodule

### rtl/core/depth_pixel_backprojection.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Back-projects depth pixels through a pinhole model into colored 3D points.
// ----------------------------------------------------------------------------
// Pixels arrive on pixel_i and points leave on point_o; both are valid/ready
// channels, and a transaction completes when valid and ready are high at a
// clock edge. The intrinsics, depth window and subsampling step are written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write them only
// while no pixel is in flight, which the block itself does not enforce. A
// pixel whose row or column is off the subsampling grid, or whose depth is
// outside the window, yields no point; every other pixel yields one point.
// Throughput is one pixel per cycle unless a stalled receiver holds the
// chain. The input stage loads at the accepting edge, then come one
// multiplier stage, one cell per quotient bit of the offset-times-depth
// product, and the output register.
// Reset clears the pipeline and loads the default camera settings.
// When the receiver stalls, the chain keeps moving until a kept point reaches
// its last cell; dropped pixels and empty slots keep flowing out.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection import bkp_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i,
  bkp_pixel_if.sink              pixel_i,
  bkp_point_if.source            point_o
);

  localparam int unsigned DiffBits =
    (COORD_BITS + SubpixBits > CfgWidth) ? COORD_BITS + SubpixBits : CfgWidth;
  localparam int unsigned ProdBits = DiffBits + DEPTH_BITS;

  cfg_t                 cfg_q;
  logic [StepWidth-1:0] step_eff;
  logic                 adv;
  color_t               color_in, color_out;

  ctrl_t                 ctrl_s     [ProdBits+1];
  logic [CfgWidth-1:0]   rem_x_s    [ProdBits+1];
  logic [ProdBits-1:0]   work_x_s   [ProdBits+1];
  logic [CfgWidth-1:0]   rem_y_s    [ProdBits+1];
  logic [ProdBits-1:0]   work_y_s   [ProdBits+1];
  logic [StepWidth-1:0]  row_rem_s  [ProdBits+1];
  logic [COORD_BITS-1:0] row_work_s [ProdBits+1];
  logic [StepWidth-1:0]  col_rem_s  [ProdBits+1];
  logic [COORD_BITS-1:0] col_work_s [ProdBits+1];
  logic [DEPTH_BITS-1:0] depth_s    [ProdBits+1];
  color_t                color_s    [ProdBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FOCAL_X:   cfg_q.focal_x   <= cfg_wdata_i;
        CFG_FOCAL_Y:   cfg_q.focal_y   <= cfg_wdata_i;
        CFG_CENTER_X:  cfg_q.center_x  <= cfg_wdata_i;
        CFG_CENTER_Y:  cfg_q.center_y  <= cfg_wdata_i;
        CFG_MIN_DEPTH: cfg_q.min_depth <= cfg_wdata_i;
        CFG_MAX_DEPTH: cfg_q.max_depth <= cfg_wdata_i;
        CFG_STEP:      cfg_q.step      <= cfg_wdata_i[StepWidth-1:0];
        default: ;
      endcase
    end
  end

  // A step of zero keeps every row and column, the same as a step of one.
  assign step_eff = (cfg_q.step == '0) ? StepWidth'(1) : cfg_q.step;

  assign pixel_i.ready  = adv;
  assign color_in.red   = pixel_i.color_byte_zero;
  assign color_in.green = pixel_i.color_byte_one;
  assign color_in.blue  = pixel_i.color_byte_two;

  bkp_front #(.COORD_BITS(COORD_BITS), .DEPTH_BITS(DEPTH_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (pixel_i.valid),
    .row_i    (pixel_i.pixel_row),
    .col_i    (pixel_i.pixel_col),
    .depth_i  (pixel_i.depth_mm),
    .color_i  (color_in),
    .cfg_i    (cfg_q),
    .ctrl_o   (ctrl_s[0]),
    .prod_x_o (work_x_s[0]),
    .prod_y_o (work_y_s[0]),
    .row_o    (row_work_s[0]),
    .col_o    (col_work_s[0]),
    .depth_o  (depth_s[0]),
    .color_o  (color_s[0])
  );

  assign rem_x_s[0]   = '0;
  assign rem_y_s[0]   = '0;
  assign row_rem_s[0] = '0;
  assign col_rem_s[0] = '0;

  for (genvar g = 0; g < ProdBits; g++) begin : g_chain
    bkp_cell #(
      .COORD_BITS (COORD_BITS),
      .DEPTH_BITS (DEPTH_BITS),
      .IDX        (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (adv),
      .focal_x_i  (cfg_q.focal_x),
      .focal_y_i  (cfg_q.focal_y),
      .step_i     (step_eff),
      .ctrl_i     (ctrl_s[g]),
      .rem_x_i    (rem_x_s[g]),
      .work_x_i   (work_x_s[g]),
      .rem_y_i    (rem_y_s[g]),
      .work_y_i   (work_y_s[g]),
      .row_rem_i  (row_rem_s[g]),
      .row_work_i (row_work_s[g]),
      .col_rem_i  (col_rem_s[g]),
      .col_work_i (col_work_s[g]),
      .depth_i    (depth_s[g]),
      .color_i    (color_s[g]),
      .ctrl_o     (ctrl_s[g+1]),
      .rem_x_o    (rem_x_s[g+1]),
      .work_x_o   (work_x_s[g+1]),
      .rem_y_o    (rem_y_s[g+1]),
      .work_y_o   (work_y_s[g+1]),
      .row_rem_o  (row_rem_s[g+1]),
      .row_work_o (row_work_s[g+1]),
      .col_rem_o  (col_rem_s[g+1]),
      .col_work_o (col_work_s[g+1]),
      .depth_o    (depth_s[g+1]),
      .color_o    (color_s[g+1])
    );
  end

  bkp_back #(.COORD_BITS(COORD_BITS), .DEPTH_BITS(DEPTH_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_s[ProdBits]),
    .mag_x_i     (work_x_s[ProdBits]),
    .mag_y_i     (work_y_s[ProdBits]),
    .depth_i     (depth_s[ProdBits]),
    .color_i     (color_s[ProdBits]),
    .focal_x_i   (cfg_q.focal_x),
    .focal_y_i   (cfg_q.focal_y),
    .out_ready_i (point_o.ready),
    .adv_o       (adv),
    .out_valid_o (point_o.valid),
    .x_o         (point_o.point_x_mm),
    .y_o         (point_o.point_y_mm),
    .z_o         (point_o.point_z_mm),
    .color_o     (color_out)
  );

  assign point_o.point_red   = color_out.red;
  assign point_o.point_green = color_out.green;
  assign point_o.point_blue  = color_out.blue;

endmodule
